FILE: src/assert_macros.svh
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Antecedent at one edge requires the consequent at the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

FILE: src/slk_pkg.sv
// Package: constants, types and the quarter-wave sine table builder.
package slk_pkg;

    localparam int SINE_DEPTH = 1024;
    localparam int SINE_AW    = 10;
    localparam int IDX_W      = 12;
    localparam int HEAD_W     = 25;
    localparam logic [HEAD_W-1:0] FULL_TURN = 25'd23592960;  // 360 deg, 16 fraction bits
    localparam logic [HEAD_W-1:0] HALF_TURN = 25'd11796480;  // 180 deg
    // phase = heading / 5760 = ((heading >> 7) * ceil(2^24 / 45)) >> 24, exact below 360 deg
    localparam int PHASE_PRE_SHIFT   = 7;
    localparam int PHASE_RECIP_SHIFT = 24;
    localparam logic [18:0] PHASE_RECIP = 19'd372828;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam int IN_W  = 112;
    localparam int OUT_W = 256;
    localparam int RES_W = 249;

    typedef logic [15:0] sine_rom_t [SINE_DEPTH];

    // Quarter-wave sine, Q30 Taylor series rounded to 16 fraction bits.
    function automatic sine_rom_t build_sine();
        sine_rom_t      rom;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint         sum;
        for (int i = 0; i < SINE_DEPTH; i++)
        begin
            x    = (HALF_PI_Q30 * longint'(i)) >> SINE_AW;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= 7; k++)
            begin
                term = (term * x2) >> 30;
                // divide by (2k)(2k+1)
                unique case (k)
                    1:       term = term / 64'd6;
                    2:       term = term / 64'd20;
                    3:       term = term / 64'd42;
                    4:       term = term / 64'd72;
                    5:       term = term / 64'd110;
                    6:       term = term / 64'd156;
                    default: term = term / 64'd210;
                endcase
                if ((k % 2) == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            sum = (sum + 8192) >>> 14;
            rom[i] = (sum > 65535) ? 16'hFFFF : sum[15:0];
        end
        return rom;
    endfunction

endpackage

FILE: src/slew_limited_kinematics_step_top.sv
// Rate-limited dead-reckoning step: speed, heading, altitude, velocity and position.
// Each accepted tick runs the sequencer from S_ACC through S_OUT before the next ready: one
// shared 33x33 signed multiplier is used eight times in sequence, once as a reciprocal
// multiplication that turns the heading into a 12-bit phase; two sine table reads
// follow. s_axis_tready is high only while the sequencer is idle; a finished result
// sits in the output register until taken, and the next tick is accepted meanwhile.
// Configuration writes are taken at any time but belong in idle periods.
module slew_limited_kinematics_step_top
    import slk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // step_time[15:0], target_speed[47:16], target_heading[72:48],
    // target_altitude[104:73], zero pad
    input  logic [IN_W-1:0]   s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // cur_speed[31:0], cur_heading[56:32], cur_altitude[88:57], vel_x[120:89],
    // vel_z[152:121], pos_x[200:153], pos_z[248:201], zero pad
    output logic [OUT_W-1:0]  m_axis_tdata,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_addr,
    input  logic [31:0]       cfg_wdata
);

    localparam logic [2:0] REG_ACCEL     = 3'd0;
    localparam logic [2:0] REG_TURN      = 3'd1;
    localparam logic [2:0] REG_CLIMB     = 3'd2;
    localparam logic [2:0] REG_SPD_FLOOR = 3'd3;
    localparam logic [2:0] REG_SPD_CEIL  = 3'd4;
    localparam logic [2:0] REG_ALT_FLOOR = 3'd5;
    localparam logic [2:0] REG_ALT_CEIL  = 3'd6;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ACC   = 4'd1;
    localparam logic [3:0] S_TURN  = 4'd2;
    localparam logic [3:0] S_CLIMB = 4'd3;
    localparam logic [3:0] S_ALT   = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_RD_S  = 4'd6;
    localparam logic [3:0] S_RD_C  = 4'd7;
    localparam logic [3:0] S_MVZ   = 4'd8;
    localparam logic [3:0] S_MVX   = 4'd9;
    localparam logic [3:0] S_MPZ   = 4'd10;
    localparam logic [3:0] S_MPX   = 4'd11;
    localparam logic [3:0] S_POSX  = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    localparam sine_rom_t SINE_ROM = build_sine();

    // configuration
    logic [30:0] accel_reg, climb_reg;
    logic [23:0] turn_reg;
    logic signed [31:0] spd_floor_reg, spd_ceil_reg, alt_floor_reg, alt_ceil_reg;

    // state
    logic [3:0]  state_reg, state_next;
    logic signed [31:0] speed_reg, altitude_reg, vx_reg, vz_reg;
    logic [HEAD_W-1:0]  heading_reg;
    logic signed [47:0] xpos_reg, zpos_reg;

    // latched tick
    logic [15:0]        dt_reg;
    logic signed [31:0] tspeed_reg, talt_reg;
    logic [HEAD_W-1:0]  thead_reg;

    // phase
    logic [IDX_W-1:0]   quot_reg;

    // trig
    logic [15:0]        rom_reg;
    logic [SINE_AW-1:0] rom_addr;
    logic signed [17:0] s_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;

    logic               out_valid_reg;
    logic [RES_W-1:0]   out_reg;

    logic [HEAD_W-1:0]  in_head;

    function automatic logic signed [31:0] clamp(input logic signed [33:0] v,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
        logic signed [33:0] lo_x;
        logic signed [33:0] hi_x;
        lo_x = 34'(lo);
        hi_x = 34'(hi);
        if (v > lo_x)
            return (v < hi_x) ? v[31:0] : hi;
        return lo;
    endfunction

    function automatic logic signed [31:0] step_to(input logic signed [31:0] cur,
                                                   input logic signed [31:0] tgt,
                                                   input logic [30:0] d,
                                                   input logic signed [31:0] lo,
                                                   input logic signed [31:0] hi);
        logic signed [33:0] c;
        logic signed [33:0] dd;
        logic signed [33:0] v;
        c  = 34'(cur);
        dd = $signed({3'b000, d});
        if (tgt > cur)
            v = c + dd;
        else if (tgt < cur)
            v = c - dd;
        else
            v = c;
        return clamp(v, lo, hi);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -34'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [47:0] pos_add(input logic signed [47:0] p,
                                                   input logic signed [32:0] d);
        logic signed [48:0] s;
        s = 49'(p) + 49'(d);
        if (s > $signed({2'b00, {47{1'b1}}}))
            return {1'b0, {47{1'b1}}};
        if (s < $signed({2'b11, {47{1'b0}}}))
            return {1'b1, {47{1'b0}}};
        return s[47:0];
    endfunction

    // Quarter lookup for a 12-bit phase: table address, exact-one flag, negate flag.
    function automatic logic [SINE_AW+1:0] phase_map(input logic [IDX_W-1:0] ph);
        logic [SINE_AW:0] j;
        if (ph[SINE_AW])
            j = (SINE_AW+1)'(SINE_DEPTH) - {1'b0, ph[SINE_AW-1:0]};
        else
            j = {1'b0, ph[SINE_AW-1:0]};
        return {ph[IDX_W-1], j};
    endfunction

    function automatic logic signed [17:0] trig_val(input logic [15:0] rd,
                                                    input logic [SINE_AW+1:0] m);
        logic signed [17:0] v;
        v = m[SINE_AW] ? 18'sd65536 : $signed({2'b00, rd});
        return m[SINE_AW+1] ? -v : v;
    endfunction

    logic [SINE_AW+1:0] sin_map, cos_map;
    logic [IDX_W-1:0]   cos_ph;

    assign cos_ph  = quot_reg + IDX_W'(SINE_DEPTH);
    assign sin_map = phase_map(quot_reg);
    assign cos_map = phase_map(cos_ph);
    assign rom_addr = (state_reg == S_RD_S) ? sin_map[SINE_AW-1:0] : cos_map[SINE_AW-1:0];

    assign in_head = (s_axis_tdata[72:48] >= FULL_TURN) ? s_axis_tdata[72:48] - FULL_TURN
                                                         : s_axis_tdata[72:48];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_W-RES_W){1'b0}}, out_reg};

    // heading step
    logic signed [26:0] hdiff, hsum;
    logic [23:0]        turn_amt;
    logic [HEAD_W-1:0]  head_new;

    always_comb
    begin
        turn_amt = prod_reg[39:16];
        hdiff    = $signed({2'b00, thead_reg}) - $signed({2'b00, heading_reg});
        hsum     = $signed({2'b00, heading_reg});
        if (hdiff > 27'sd0)
        begin
            if (hdiff > $signed({2'b00, HALF_TURN}))
                hsum = hsum - $signed({3'b000, turn_amt});
            else
                hsum = hsum + $signed({3'b000, turn_amt});
        end
        else if (hdiff < 27'sd0)
        begin
            if (hdiff < -$signed({2'b00, HALF_TURN}))
                hsum = hsum + $signed({3'b000, turn_amt});
            else
                hsum = hsum - $signed({3'b000, turn_amt});
        end
        if (hsum < 27'sd0)
            head_new = HEAD_W'(hsum + $signed({2'b00, FULL_TURN}));
        else if (hsum >= $signed({2'b00, FULL_TURN}))
            head_new = HEAD_W'(hsum - $signed({2'b00, FULL_TURN}));
        else
            head_new = hsum[HEAD_W-1:0];
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = $signed({17'd0, dt_reg});
        unique case (state_reg)
            S_ACC:   mul_a = $signed({2'b00, accel_reg});
            S_TURN:  mul_a = $signed({9'd0, turn_reg});
            S_CLIMB: mul_a = $signed({2'b00, climb_reg});
            S_ALT:
            begin
                mul_a = $signed({15'd0, heading_reg[HEAD_W-1:PHASE_PRE_SHIFT]});
                mul_b = $signed({14'd0, PHASE_RECIP});
            end
            S_MVZ:
            begin
                mul_a = 33'(speed_reg);
                mul_b = 33'(s_reg);
            end
            S_MVX:
            begin
                mul_a = 33'(speed_reg);
                mul_b = 33'(trig_val(rom_reg, cos_map));
            end
            S_MPZ:   mul_a = 33'(vz_reg);
            S_MPX:   mul_a = 33'(vx_reg);
            default: mul_a = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_axis_tvalid) state_next = S_ACC;
            S_ACC:   state_next = S_TURN;
            S_TURN:  state_next = S_CLIMB;
            S_CLIMB: state_next = S_ALT;
            S_ALT:   state_next = S_DIV;
            S_DIV:   state_next = S_RD_S;
            S_RD_S:  state_next = S_RD_C;
            S_RD_C:  state_next = S_MVZ;
            S_MVZ:   state_next = S_MVX;
            S_MVX:   state_next = S_MPZ;
            S_MPZ:   state_next = S_MPX;
            S_MPX:   state_next = S_POSX;
            S_POSX:  state_next = S_OUT;
            S_OUT:   if (!out_valid_reg || m_axis_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            accel_reg     <= 31'd65536;
            turn_reg      <= 24'd655360;
            climb_reg     <= 31'd65536;
            spd_floor_reg <= 32'sd0;
            spd_ceil_reg  <= 32'sd6553600;
            alt_floor_reg <= 32'sd0;
            alt_ceil_reg  <= 32'sd6553600;
            speed_reg     <= '0;
            heading_reg   <= '0;
            altitude_reg  <= '0;
            xpos_reg      <= '0;
            zpos_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_ACCEL:     accel_reg     <= cfg_wdata[30:0];
                    REG_TURN:      turn_reg      <= cfg_wdata[23:0];
                    REG_CLIMB:     climb_reg     <= cfg_wdata[30:0];
                    REG_SPD_FLOOR: spd_floor_reg <= cfg_wdata;
                    REG_SPD_CEIL:  spd_ceil_reg  <= cfg_wdata;
                    REG_ALT_FLOOR: alt_floor_reg <= cfg_wdata;
                    REG_ALT_CEIL:  alt_ceil_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            // load a new result or hold the one not yet taken
            out_valid_reg <= (state_reg == S_OUT && (!out_valid_reg || m_axis_tready)) ||
                             (out_valid_reg && !m_axis_tready);
            unique case (state_reg)
                S_TURN:
                    speed_reg <= step_to(speed_reg, tspeed_reg, prod_reg[46:16],
                                         spd_floor_reg, spd_ceil_reg);
                S_CLIMB: heading_reg <= head_new;
                S_ALT:
                    altitude_reg <= step_to(altitude_reg, talt_reg, prod_reg[46:16],
                                            alt_floor_reg, alt_ceil_reg);
                S_MPX:  zpos_reg <= pos_add(zpos_reg, prod_reg[48:16]);
                S_POSX: xpos_reg <= pos_add(xpos_reg, prod_reg[48:16]);
                default: ;
            endcase
        end
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (state_reg == S_IDLE && s_axis_tvalid)
        begin
            dt_reg     <= s_axis_tdata[15:0];
            tspeed_reg <= s_axis_tdata[47:16];
            thead_reg  <= in_head;
            talt_reg   <= s_axis_tdata[104:73];
        end
        if (state_reg == S_DIV)
            quot_reg <= prod_reg[PHASE_RECIP_SHIFT+IDX_W-1:PHASE_RECIP_SHIFT];
        if (state_reg == S_RD_S || state_reg == S_RD_C)
            rom_reg <= SINE_ROM[rom_addr];
        if (state_reg == S_RD_C)
            s_reg <= trig_val(rom_reg, sin_map);
        if (state_reg == S_MVX)
            vz_reg <= sat32(prod_reg[49:16]);
        if (state_reg == S_MPZ)
            vx_reg <= sat32(prod_reg[49:16]);
        if (state_reg == S_OUT && (!out_valid_reg || m_axis_tready))
            out_reg <= {zpos_reg, xpos_reg, vz_reg, vx_reg, altitude_reg,
                        heading_reg, speed_reg};
    end

endmodule

FILE: src/slk_checker.sv
// Port-level checker for the kinematics step block, bound to the top level.
`include "assert_macros.svh"

module slk_port_checker
    import slk_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `ASSERT_ALWAYS(a_result_from_work, clk, rst_n, !$rose(m_axis_tvalid) || !$past(s_axis_tready))
    `ASSERT_ALWAYS(a_pad_zero, clk, rst_n, m_axis_tdata[OUT_W-1:RES_W] == '0)

endmodule

bind slew_limited_kinematics_step_top slk_port_checker u_slk_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: bench/slk_bench_pkg.sv
// Bench package: configuration register indexes shared by the bench files.
package slk_bench_pkg;

    typedef enum logic [2:0]
    {
        REG_ACCEL_RATE,
        REG_TURN_RATE,
        REG_CLIMB_RATE,
        REG_SPEED_FLOOR,
        REG_SPEED_CEILING,
        REG_ALT_FLOOR,
        REG_ALT_CEILING,
        REG_UNUSED
    } slk_reg_e;

endpackage

FILE: bench/slk_checker.sv
// Checker: follows the body state for each tick and compares every output transaction.
module slk_checker
    import slk_pkg::*;
    import slk_bench_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    input  logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,
    input  logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    input  logic [OUT_W-1:0] m_axis_tdata,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_addr,
    input  logic [31:0]      cfg_wdata,
    output int               fail_count,
    output int               pending,
    output int               results_seen
);

    localparam longint FULL_DEG = longint'(360) <<< 16;
    localparam longint HALF_DEG = longint'(180) <<< 16;

    typedef struct packed
    {
        logic [47:0] pos_z;
        logic [47:0] pos_x;
        logic [31:0] vel_z;
        logic [31:0] vel_x;
        logic [31:0] altitude;
        logic [24:0] heading;
        logic [31:0] speed;
    } body_state_t;

    logic [15:0] quarter_sine [SINE_DEPTH];

    longint          speed_now;
    longint          heading_now;
    longint          altitude_now;
    longint          pos_x_now;
    longint          pos_z_now;
    longint unsigned accel_rate;
    longint unsigned turn_rate;
    longint unsigned climb_rate;
    longint          speed_lo;
    longint          speed_hi;
    longint          alt_lo;
    longint          alt_hi;

    body_state_t expected_ticks [$];

    // Quarter-wave sine: Q30 Taylor series with seven correction terms.
    initial
    begin
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        for (int i = 0; i < SINE_DEPTH; i++)
        begin
            x    = (HALF_PI_Q30 * longint'(i)) / SINE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            for (int k = 1; k <= 7; k++)
            begin
                term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            acc = (acc + 8192) >>> 14;
            quarter_sine[i] = (acc > 65535) ? 16'hFFFF : acc[15:0];
        end
    end

    function automatic longint clip_signed(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function automatic longint clamp_range(longint v, longint lo, longint hi);
        return (v > lo) ? ((v < hi) ? v : hi) : lo;
    endfunction

    function automatic longint slew(longint cur, longint target, longint unsigned rate,
                                    longint unsigned dt);
        longint d;
        d = longint'((rate * dt) >> 16);
        if (target > cur)
            return cur + d;
        if (target < cur)
            return cur - d;
        return cur;
    endfunction

    function automatic longint table_entry(longint unsigned j);
        return (j >= SINE_DEPTH) ? longint'(65536) : longint'(quarter_sine[j]);
    endfunction

    function automatic longint sine_phase(longint unsigned idx);
        longint unsigned q;
        longint unsigned o;
        idx = idx % (4 * SINE_DEPTH);
        q   = idx / SINE_DEPTH;
        o   = idx % SINE_DEPTH;
        case (q)
            0:       return table_entry(o);
            1:       return table_entry(SINE_DEPTH - o);
            2:       return -table_entry(o);
            default: return -table_entry(SINE_DEPTH - o);
        endcase
    endfunction

    // Advance the body by one tick and return the state it reports.
    function automatic body_state_t advance_body(logic [IN_W-1:0] tick);
        body_state_t     r;
        longint unsigned dt;
        longint          tgt_head;
        longint          h;
        longint          diff;
        longint          turn;
        longint unsigned idx;
        longint          vx;
        longint          vz;
        dt       = tick[15:0];
        tgt_head = longint'(tick[72:48]) % FULL_DEG;

        speed_now = slew(speed_now, longint'(signed'(tick[47:16])), accel_rate, dt);
        speed_now = clamp_range(speed_now, speed_lo, speed_hi);

        h    = heading_now;
        diff = tgt_head - h;
        turn = longint'((turn_rate * dt) >> 16);
        if (diff > 0)
            h = (diff > HALF_DEG) ? h - turn : h + turn;
        else if (diff < 0)
            h = (diff < -HALF_DEG) ? h + turn : h - turn;
        heading_now = ((h % FULL_DEG) + FULL_DEG) % FULL_DEG;

        idx = (longint'(heading_now) * 4 * SINE_DEPTH) / FULL_DEG;
        vx  = clip_signed((speed_now * sine_phase(idx + SINE_DEPTH)) >>> 16, 32);
        vz  = clip_signed((speed_now * sine_phase(idx)) >>> 16, 32);

        altitude_now = slew(altitude_now, longint'(signed'(tick[104:73])), climb_rate, dt);
        altitude_now = clamp_range(altitude_now, alt_lo, alt_hi);

        pos_x_now = clip_signed(pos_x_now + ((vx * longint'(dt)) >>> 16), 48);
        pos_z_now = clip_signed(pos_z_now + ((vz * longint'(dt)) >>> 16), 48);

        r.speed    = speed_now[31:0];
        r.heading  = heading_now[24:0];
        r.altitude = altitude_now[31:0];
        r.vel_x    = vx[31:0];
        r.vel_z    = vz[31:0];
        r.pos_x    = pos_x_now[47:0];
        r.pos_z    = pos_z_now[47:0];
        return r;
    endfunction

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH result %0d %s: got %h expected %h", results_seen, field, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        body_state_t want;
        body_state_t got;
        if (!rst_n)
        begin
            speed_now    = 0;
            heading_now  = 0;
            altitude_now = 0;
            pos_x_now    = 0;
            pos_z_now    = 0;
            accel_rate   = 65536;
            turn_rate    = 655360;
            climb_rate   = 65536;
            speed_lo     = 0;
            speed_hi     = 6553600;
            alt_lo       = 0;
            alt_hi       = 6553600;
            fail_count   = 0;
            results_seen = 0;
            expected_ticks.delete();
            pending      = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (slk_reg_e'(cfg_addr))
                    REG_ACCEL_RATE:    accel_rate = cfg_wdata[30:0];
                    REG_TURN_RATE:     turn_rate  = cfg_wdata[23:0];
                    REG_CLIMB_RATE:    climb_rate = cfg_wdata[30:0];
                    REG_SPEED_FLOOR:   speed_lo   = longint'(signed'(cfg_wdata));
                    REG_SPEED_CEILING: speed_hi   = longint'(signed'(cfg_wdata));
                    REG_ALT_FLOOR:     alt_lo     = longint'(signed'(cfg_wdata));
                    REG_ALT_CEILING:   alt_hi     = longint'(signed'(cfg_wdata));
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_ticks.push_back(advance_body(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[248:0];
                if (expected_ticks.size() == 0)
                begin
                    $display("UNEXPECTED result %0d: %h", results_seen, got);
                    fail_count++;
                end
                else
                begin
                    want = expected_ticks.pop_front();
                    if (got.speed !== want.speed)
                        report("cur_speed", got.speed, want.speed);
                    if (got.heading !== want.heading)
                        report("cur_heading", got.heading, want.heading);
                    if (got.altitude !== want.altitude)
                        report("cur_altitude", got.altitude, want.altitude);
                    if (got.vel_x !== want.vel_x)
                        report("vel_x", got.vel_x, want.vel_x);
                    if (got.vel_z !== want.vel_z)
                        report("vel_z", got.vel_z, want.vel_z);
                    if (got.pos_x !== want.pos_x)
                        report("pos_x", got.pos_x, want.pos_x);
                    if (got.pos_z !== want.pos_z)
                        report("pos_z", got.pos_z, want.pos_z);
                end
                results_seen++;
            end
            pending = expected_ticks.size();
        end
    end

endmodule

FILE: bench/tb_slew_limited_kinematics_step_top.sv
// Testbench top: clock, reset, tick stimulus, configuration phases and verdict.
module tb_slew_limited_kinematics_step_top;
    import slk_pkg::*;
    import slk_bench_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             cfg_we;
    logic [2:0]       cfg_addr;
    logic [31:0]      cfg_wdata;

    int fail_count;
    int pending;
    int results_seen;
    int ticks_sent;
    int burst_left;
    int cycles;

    slew_limited_kinematics_step_top DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    slk_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen)
    );

    initial
        clk = 1'b0;
    always
        #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("slew_limited_kinematics_step_top verification failed");
            $finish;
        end
    end

    // Receiver: random stalls until the stream is going, one long hold-off, then a
    // windowed stall pattern.
    initial
    begin
        int mode;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        while (ticks_sent < 40)
        begin
            @(negedge clk);
            m_axis_tready <= 1'($urandom_range(0, 1));
        end
        @(negedge clk);
        m_axis_tready <= 1'b0;
        repeat (400)
            @(negedge clk);
        forever
        begin
            mode = $urandom_range(0, 2);
            repeat (32)
            begin
                @(negedge clk);
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic write_reg(slk_reg_e r, logic [31:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_tick(logic [15:0] dt, logic [31:0] spd, logic [24:0] hdg,
                             logic [31:0] alt);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, alt, hdg, spd, dt};
        do
            @(posedge clk);
        while (!s_axis_tready);
        ticks_sent++;
        if (--burst_left <= 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 20))
                @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
    endtask

    function automatic logic [15:0] pick_dt();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    // Targets mostly near the working range, sometimes anywhere in 32 bits.
    function automatic logic [31:0] pick_level();
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return 32'sd0 - $urandom_range(0, 32'h00FF_FFFF);
            default: return $urandom_range(0, 32'h00FF_FFFF);
        endcase
    endfunction

    function automatic logic [24:0] pick_heading();
        case ($urandom_range(0, 5))
            0:       return 25'($urandom);
            1:       return HALF_TURN;
            default: return 25'($urandom_range(0, FULL_TURN - 1));
        endcase
    endfunction

    task automatic random_ticks(int n);
        repeat (n)
            send_tick(pick_dt(), pick_level(), pick_heading(), pick_level());
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        ticks_sent    = 0;
        cycles        = 0;
        burst_left    = 4;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero step, half-turn tie, heading past 360, return to exactly zero.
        send_tick(16'h0000, 32'h0000_0000, 25'd0, 32'h0000_0000);
        send_tick(16'hFFFF, 32'h7FFF_FFFF, HALF_TURN, 32'h7FFF_FFFF);
        send_tick(16'hFFFF, 32'h8000_0000, 25'h1FF_FFFF, 32'h8000_0000);
        send_tick(16'hFFFF, 32'h0001_0000, 25'd0, 32'h0001_0000);
        send_tick(16'h8000, 32'h0064_0000, FULL_TURN - 1, 32'h0064_0000);
        send_tick(16'hFFFF, 32'h0000_0000, 25'd0, 32'h0000_0000);
        send_tick(16'h0001, 32'h0010_0000, 25'd5760, 32'h0010_0000);
        send_tick(16'h4000, 32'h0000_0000, 25'd0, 32'hFFFF_0000);
        wait_idle();

        // Extremes: fastest slew and widest limits.
        write_reg(REG_ACCEL_RATE, 32'hFFFF_FFFF);
        write_reg(REG_TURN_RATE, 32'h00B3_FFFF);
        write_reg(REG_CLIMB_RATE, 32'h7FFF_FFFF);
        write_reg(REG_SPEED_FLOOR, 32'h8000_0000);
        write_reg(REG_SPEED_CEILING, 32'h7FFF_FFFF);
        write_reg(REG_ALT_FLOOR, 32'h8000_0000);
        write_reg(REG_ALT_CEILING, 32'h7FFF_FFFF);
        write_reg(REG_UNUSED, 32'h1234_5678);
        send_tick(16'hFFFF, 32'h7FFF_FFFF, HALF_TURN, 32'h7FFF_FFFF);
        send_tick(16'hFFFF, 32'h7FFF_FFFF, 25'd0, 32'h8000_0000);
        send_tick(16'hFFFF, 32'h8000_0000, FULL_TURN - 1, 32'h8000_0000);
        random_ticks(120);
        wait_idle();

        // Stalled slew and floors above ceilings.
        write_reg(REG_ACCEL_RATE, 32'h0000_0000);
        write_reg(REG_TURN_RATE, 32'h0000_0000);
        write_reg(REG_CLIMB_RATE, 32'h0000_0000);
        write_reg(REG_SPEED_FLOOR, 32'h0050_0000);
        write_reg(REG_SPEED_CEILING, 32'hFFF0_0000);
        write_reg(REG_ALT_FLOOR, 32'h0010_0000);
        write_reg(REG_ALT_CEILING, 32'h0008_0000);
        random_ticks(40);
        wait_idle();

        write_reg(REG_ACCEL_RATE, 32'h0040_0000);
        write_reg(REG_TURN_RATE, 32'h00B0_0000);
        write_reg(REG_CLIMB_RATE, 32'h0020_0000);
        random_ticks(60);
        wait_idle();

        // Random settings, kept mostly ordered so the slew has room to act.
        repeat (3)
        begin
            write_reg(REG_ACCEL_RATE, $urandom);
            write_reg(REG_TURN_RATE, $urandom);
            write_reg(REG_CLIMB_RATE, $urandom_range(0, 32'h0100_0000));
            write_reg(REG_SPEED_FLOOR, 32'sd0 - $urandom_range(0, 32'h0400_0000));
            write_reg(REG_SPEED_CEILING, $urandom_range(0, 32'h7FFF_FFFF));
            write_reg(REG_ALT_FLOOR, $urandom);
            write_reg(REG_ALT_CEILING, $urandom_range(0, 32'h7FFF_FFFF));
            random_ticks(95);
            wait_idle();
        end

        $display("covered %0d ticks and %0d results over seven register settings,",
                 ticks_sent, results_seen);
        $display("including zero and full steps, half-turn ties, inverted limits, long stall");
        if (fail_count == 0 && pending == 0)
            $display("slew_limited_kinematics_step_top verification clean");
        else
            $display("slew_limited_kinematics_step_top verification failed");
        $finish;
    end

endmodule
